// ===== hdl/lifo_pkg.sv =====
// lifo_pkg: command codes, status codes and the control/status structs
// shared by the stack controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lifo_pkg;

  // command codes on the cmd field
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_DUMP   = 3'd2;
  localparam logic [2:0] CMD_PEEK   = 3'd3;
  localparam logic [2:0] CMD_CHANGE = 3'd4;

  localparam int PLACE_W = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  // read address sources
  typedef enum logic [1:0] {
    RD_TOP,
    RD_SLOT,
    RD_BOTTOM,
    RD_WALK
  } rd_sel_t;

  // write address sources
  typedef enum logic {
    WR_TOP,
    WR_SLOT
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    walk_clr;
    logic    walk_inc;
    logic    load_direct;
    status_t dir_status;
    logic    use_slot;
    logic    load_read;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic slot_ok;
    logic more;
  } dp_sts_t;

endpackage

// ===== hdl/lifo_stack_with_indexed_access.sv =====
// Bounded stack with push, pop, indexed peek/change and bottom-up dump.
// Push, change and errors load the response registers straight from the
// request beat; pop and peek first take the registered memory read. A new
// request is taken only once the last response beat is accepted; a dump
// streams its elements with one read and one response beat per element.
// Reset (rst, synchronous) empties the stack; memory contents are not cleared.
`timescale 1ns / 1ps

module lifo_stack_with_indexed_access import lifo_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         cmd,
  input  logic [7:0]         slot,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic signed [31:0] word,
  output logic [4:0]         place,
  output logic               last
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  // command sequencer
  lifo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // storage and response datapath
  lifo_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .slot   (slot),
    .value  (value),
    .ctl    (ctl),
    .sts    (sts),
    .status (status),
    .word   (word),
    .place  (place),
    .last   (last)
  );

endmodule

// ===== hdl/lifo_ctrl.sv =====
// lifo_ctrl: command sequencer for the stack; decodes each request beat and
// steps the datapath through memory reads and response beats. Uses lifo_pkg.
`timescale 1ns / 1ps

module lifo_ctrl import lifo_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [2:0] cmd,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_sts_t    sts,
  output dp_ctl_t    ctl
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (cmd)
            CMD_PUSH: state_next = S_EMIT;
            CMD_POP, CMD_DUMP: state_next = sts.empty ? S_EMIT : S_FETCH;
            CMD_PEEK: state_next = (sts.empty || !sts.slot_ok) ? S_EMIT : S_FETCH;
            CMD_CHANGE: state_next = S_EMIT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FETCH: state_next = S_EMIT;
      S_EMIT: begin
        if (rsp_ready) begin
          state_next = sts.more ? S_FETCH : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    ctl.wr_sel = WR_TOP;
    ctl.rd_sel = RD_TOP;
    ctl.dir_status = ST_OK;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        ctl.take = req_valid;
        if (req_valid) begin
          unique case (cmd)
            CMD_PUSH: begin
              ctl.load_direct = 1'b1;
              if (sts.full) begin
                ctl.dir_status = ST_FULL;
              end else begin
                ctl.wr_en   = 1'b1;
                ctl.wr_sel  = WR_TOP;
                ctl.cnt_inc = 1'b1;
              end
            end
            CMD_POP: begin
              if (sts.empty) begin
                ctl.load_direct = 1'b1;
                ctl.dir_status  = ST_EMPTY;
              end else begin
                ctl.cnt_dec = 1'b1;
                ctl.rd_en   = 1'b1;
                ctl.rd_sel  = RD_TOP;
              end
            end
            CMD_DUMP: begin
              if (sts.empty) begin
                ctl.load_direct = 1'b1;
                ctl.dir_status  = ST_EMPTY;
              end else begin
                ctl.rd_en    = 1'b1;
                ctl.rd_sel   = RD_BOTTOM;
                ctl.walk_clr = 1'b1;
              end
            end
            CMD_PEEK, CMD_CHANGE: begin
              if (sts.empty) begin
                ctl.load_direct = 1'b1;
                ctl.dir_status  = ST_EMPTY;
              end else if (!sts.slot_ok) begin
                ctl.load_direct = 1'b1;
                ctl.dir_status  = ST_RANGE;
              end else if (cmd == CMD_PEEK) begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = RD_SLOT;
              end else begin
                ctl.wr_en       = 1'b1;
                ctl.wr_sel      = WR_SLOT;
                ctl.load_direct = 1'b1;
                ctl.use_slot    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: ctl.load_read = 1'b1;
      S_EMIT: begin
        rsp_valid = 1'b1;
        if (rsp_ready && sts.more) begin
          ctl.rd_en    = 1'b1;
          ctl.rd_sel   = RD_WALK;
          ctl.walk_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // a read is always followed by its response beat
  a_fetch_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_EMIT))
    else $error("fetch not followed by emit");

  // only one side of the stack interface is open at a time
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request and response open together");

  // a dump continuation reads the next element
  a_walk_reads: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && sts.more) |=> (state == S_FETCH))
    else $error("dump step lost");

endmodule

// ===== hdl/lifo_dpath.sv =====
// lifo_dpath: element memory, occupancy count, dump walker and response
// registers for the stack. Uses lifo_pkg; driven by lifo_ctrl.
`timescale 1ns / 1ps

module lifo_dpath import lifo_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         cmd,
  input  logic [7:0]         slot,
  input  logic signed [31:0] value,
  input  dp_ctl_t            ctl,
  output dp_sts_t            sts,
  output logic [1:0]         status,
  output logic signed [31:0] word,
  output logic [4:0]         place,
  output logic               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [CW-1:0]      count;
  logic [AW-1:0]      walk;
  logic [7:0]         slot_q;
  logic               op_peek;
  logic               op_walk;
  logic [CW-1:0]      walk_plus;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      slot_addr;

  assign walk_plus = CW'(walk) + CW'(1);
  assign slot_addr = AW'(count - CW'(slot));

  // status toward the controller
  assign sts.empty   = (count == '0);
  assign sts.full    = (count == CW'(DEPTH));
  assign sts.slot_ok = (slot != '0) && (slot <= 8'(count));
  assign sts.more    = op_walk && (walk_plus != count);

  // address selection
  always_comb begin
    case (ctl.rd_sel)
      RD_TOP:    rd_addr = AW'(count - CW'(1));
      RD_SLOT:   rd_addr = slot_addr;
      RD_BOTTOM: rd_addr = '0;
      RD_WALK:   rd_addr = AW'(walk_plus);
      default:   rd_addr = '0;
    endcase
    wr_addr = (ctl.wr_sel == WR_SLOT) ? slot_addr : AW'(count);
  end

  // element memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= value;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // command context and dump walker
  always_ff @(posedge clk) begin
    if (rst) begin
      op_walk <= 1'b0;
      op_peek <= 1'b0;
    end else if (ctl.take) begin
      op_walk <= (cmd == CMD_DUMP) && ctl.rd_en;
      op_peek <= (cmd == CMD_PEEK);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      slot_q <= slot;
    end
    if (ctl.walk_clr) begin
      walk <= '0;
    end else if (ctl.walk_inc) begin
      walk <= AW'(walk_plus);
    end
  end

  // response beat registers
  always_ff @(posedge clk) begin
    if (ctl.load_direct) begin
      status <= ctl.dir_status;
      word   <= (ctl.dir_status == ST_OK) ? value : '0;
      place  <= ctl.use_slot ? PLACE_W'(slot) : '0;
      last   <= 1'b1;
    end else if (ctl.load_read) begin
      status <= ST_OK;
      word   <= rd_data;
      if (op_walk) begin
        place <= PLACE_W'(walk_plus);
      end else if (op_peek) begin
        place <= PLACE_W'(slot_q);
      end else begin
        place <= '0;
      end
      last <= !sts.more;
    end
  end

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stack count above capacity");

  // a push grows the stack by one
  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_inc |=> (count == $past(count) + CW'(1)))
    else $error("push did not grow count");

  // a pop shrinks the stack by one
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_dec |=> (count == $past(count) - CW'(1)))
    else $error("pop did not shrink count");

endmodule
